>>> design/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int MI3_DATA_WIDTH = 32;
  localparam int MI3_FRAC_BITS  = 16;
  localparam int MI3_N          = 9;

  // Cofactor k = a[x]*a[y] - a[u]*a[v], row-major element indices {x, y, u, v}
  localparam int MI3_CF_IDX [0:MI3_N-1][0:3] = '{
    '{4, 8, 7, 5},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 3, 1}
  };

endpackage

>>> design/mi3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_in_if / mi3_out_if
// Valid/ready channels carrying one matrix beat and one inverse beat.
// ----------------------------------------------------------------------------
interface mi3_in_if #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3_out_if #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                         singular;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, output ready);
endinterface

>>> design/mi3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: the eighteen element products, then the nine adjugate cofactors.
// ----------------------------------------------------------------------------
module mi3_cof #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic signed [DATA_WIDTH-1:0] a_i   [0:mi3_pkg::MI3_N-1],
  output logic                         vld_o,
  output logic signed [DATA_WIDTH-1:0] a_o   [0:mi3_pkg::MI3_N-1],
  output logic signed [2*DATA_WIDTH:0] cof_o [0:mi3_pkg::MI3_N-1]
);
  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;

  logic signed [2*W-1:0] prod_nxt [0:MI3_N-1][0:1];
  logic signed [2*W-1:0] prod_r   [0:MI3_N-1][0:1];
  logic signed [2*W:0]   cof_nxt  [0:MI3_N-1];
  logic signed [2*W:0]   cof_r    [0:MI3_N-1];
  logic signed [W-1:0]   a1_r     [0:MI3_N-1];
  logic signed [W-1:0]   a2_r     [0:MI3_N-1];
  logic                  v1_r, v2_r;

  // Form both products of every cofactor
  always_comb begin
    for (int k = 0; k < MI3_N; k++) begin
      prod_nxt[k][0] = a_i[MI3_CF_IDX[k][0]] * a_i[MI3_CF_IDX[k][1]];
      prod_nxt[k][1] = a_i[MI3_CF_IDX[k][2]] * a_i[MI3_CF_IDX[k][3]];
    end
  end

  // Subtract the pair, one bit of headroom
  always_comb begin
    for (int k = 0; k < MI3_N; k++) begin
      cof_nxt[k] = prod_r[k][0] - prod_r[k][1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      a1_r   <= a_i;
      cof_r  <= cof_nxt;
      a2_r   <= a1_r;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  assign vld_o = v2_r;
  assign a_o   = a2_r;
  assign cof_o = cof_r;

endmodule

>>> design/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: split products of the first row with its cofactors, combine,
// sum into the exact determinant, then take magnitudes and signs.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic signed [DATA_WIDTH-1:0] a_i    [0:mi3_pkg::MI3_N-1],
  input  logic signed [2*DATA_WIDTH:0] cof_i  [0:mi3_pkg::MI3_N-1],
  output logic                         vld_o,
  output logic                         sing_o,
  output logic [3*DATA_WIDTH+2:0]      dmag_o,
  output logic [2*DATA_WIDTH:0]        nmag_o [0:mi3_pkg::MI3_N-1],
  output logic                         neg_o  [0:mi3_pkg::MI3_N-1]
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int TW  = 3 * W + 1;
  localparam int DSW = 3 * W + 3;

  logic signed [2*W:0]  lo_nxt [0:2];
  logic signed [2*W:0]  hi_nxt [0:2];
  logic signed [2*W:0]  lo_r   [0:2];
  logic signed [2*W:0]  hi_r   [0:2];
  logic signed [TW-1:0] t_nxt  [0:2];
  logic signed [TW-1:0] t_r    [0:2];
  logic signed [DSW-1:0] det_nxt, det_r;
  logic signed [2*W:0]  cof1_r [0:MI3_N-1];
  logic signed [2*W:0]  cof2_r [0:MI3_N-1];
  logic signed [2*W:0]  cof3_r [0:MI3_N-1];
  logic [DSW-1:0]       dmag_nxt, dmag_r;
  logic                 sing_nxt, sing_r;
  logic [2*W:0]         nmag_nxt [0:MI3_N-1];
  logic [2*W:0]         nmag_r   [0:MI3_N-1];
  logic                 neg_nxt  [0:MI3_N-1];
  logic                 neg_r    [0:MI3_N-1];
  logic [3:0]           v_r;

  // Split each cofactor into a low unsigned half and a high signed half
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_nxt[j] = a_i[j] * $signed({1'b0, cof_i[3*j][W-1:0]});
      hi_nxt[j] = a_i[j] * $signed(cof_i[3*j][2*W:W]);
    end
  end

  // Recombine the halves
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t_nxt[j] = (TW'(hi_r[j]) <<< W) + TW'(lo_r[j]);
    end
  end

  // Sum the three terms
  assign det_nxt = DSW'(t_r[0]) + DSW'(t_r[1]) + DSW'(t_r[2]);

  // Take magnitudes and quotient signs
  always_comb begin
    sing_nxt = (det_r == '0);
    dmag_nxt = det_r[DSW-1] ? DSW'(-det_r) : DSW'(det_r);
    for (int k = 0; k < MI3_N; k++) begin
      nmag_nxt[k] = cof3_r[k][2*W] ? (2*W+1)'(-cof3_r[k]) : (2*W+1)'(cof3_r[k]);
      neg_nxt[k]  = cof3_r[k][2*W] ^ det_r[DSW-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      t_r    <= t_nxt;
      det_r  <= det_nxt;
      cof1_r <= cof_i;
      cof2_r <= cof1_r;
      cof3_r <= cof2_r;
      dmag_r <= dmag_nxt;
      sing_r <= sing_nxt;
      nmag_r <= nmag_nxt;
      neg_r  <= neg_nxt;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], vld_i};
    end
  end

  assign vld_o  = v_r[3];
  assign sing_o = sing_r;
  assign dmag_o = dmag_r;
  assign nmag_o = nmag_r;
  assign neg_o  = neg_r;

endmodule

>>> design/mi3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Nine-lane restoring divider, one quotient bit per stage, sharing the
// divisor. Produces twice the quotient, then rounds, saturates and signs.
// ----------------------------------------------------------------------------
module mi3_div #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH,
  parameter int FRAC_BITS  = mi3_pkg::MI3_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic                         sing_i,
  input  logic [3*DATA_WIDTH+2:0]      d_i,
  input  logic [2*DATA_WIDTH:0]        n_i   [0:mi3_pkg::MI3_N-1],
  input  logic                         neg_i [0:mi3_pkg::MI3_N-1],
  output logic                         vld_o,
  output logic                         sing_o,
  output logic signed [DATA_WIDTH-1:0] r_o   [0:mi3_pkg::MI3_N-1]
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int QB  = W + 2;
  localparam int N2W = MW + 2 * F + 1;
  localparam int UW  = N2W - QB;
  localparam int CW  = (UW > DW) ? UW : DW;

  logic [N2W-1:0] n2_w     [0:MI3_N-1];
  logic [CW-1:0]  up_w     [0:MI3_N-1];
  logic [DW-1:0]  rem0_nxt [0:MI3_N-1];
  logic [QB-1:0]  nb0_nxt  [0:MI3_N-1];
  logic           ov0_nxt  [0:MI3_N-1];

  logic [DW-1:0]  d_r   [0:QB-1];
  logic [DW-1:0]  rem_r [0:QB-1][0:MI3_N-1];
  logic [QB-1:0]  nb_r  [0:QB-1][0:MI3_N-1];
  logic [QB-1:0]  q_r   [1:QB][0:MI3_N-1];
  logic           ov_r  [0:QB][0:MI3_N-1];
  logic           neg_r [0:QB][0:MI3_N-1];
  logic           sing_r [0:QB];
  logic           vld_r  [0:QB];

  logic [QB:0]    qinc_w  [0:MI3_N-1];
  logic [QB-1:0]  qh_w    [0:MI3_N-1];
  logic [QB-1:0]  lim_w   [0:MI3_N-1];
  logic [W-1:0]   mag_w   [0:MI3_N-1];
  logic [W-1:0]   res_nxt [0:MI3_N-1];
  logic [W-1:0]   res_r   [0:MI3_N-1];
  logic           out_sing_r;
  logic           out_vld_r;

  // Scale the numerator, peel the bits above the quotient, flag overflow
  always_comb begin
    for (int k = 0; k < MI3_N; k++) begin
      n2_w[k]     = N2W'(n_i[k]) << (2 * F + 1);
      up_w[k]     = CW'(n2_w[k] >> QB);
      ov0_nxt[k]  = (up_w[k] >= CW'(d_i));
      rem0_nxt[k] = DW'(up_w[k]);
      nb0_nxt[k]  = n2_w[k][QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]    <= d_i;
      rem_r[0]  <= rem0_nxt;
      nb_r[0]   <= nb0_nxt;
      ov_r[0]   <= ov0_nxt;
      neg_r[0]  <= neg_i;
      sing_r[0] <= sing_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  // One quotient bit per stage
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW:0] trial_w [0:MI3_N-1];
    logic [DW:0] diff_w  [0:MI3_N-1];
    logic        ge_w    [0:MI3_N-1];

    always_comb begin
      for (int k = 0; k < MI3_N; k++) begin
        trial_w[k] = {rem_r[s-1][k], nb_r[s-1][k][QB-1]};
        diff_w[k]  = trial_w[k] - {1'b0, d_r[s-1]};
        ge_w[k]    = (trial_w[k] >= {1'b0, d_r[s-1]});
      end
    end

    if (s == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < MI3_N; k++) begin
            q_r[s][k] <= {{(QB-1){1'b0}}, ge_w[k]};
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < MI3_N; k++) begin
            q_r[s][k] <= {q_r[s-1][k][QB-2:0], ge_w[k]};
          end
        end
      end
    end

    if (s < QB) begin : g_rem
      logic [DW-1:0] rem_nxt [0:MI3_N-1];

      always_comb begin
        for (int k = 0; k < MI3_N; k++) begin
          rem_nxt[k] = ge_w[k] ? diff_w[k][DW-1:0] : trial_w[k][DW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_r[s]   <= d_r[s-1];
          rem_r[s] <= rem_nxt;
          for (int k = 0; k < MI3_N; k++) begin
            nb_r[s][k] <= nb_r[s-1][k] << 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ov_r[s]   <= ov_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Round half away from zero, clamp, apply sign, zero a singular result
  always_comb begin
    for (int k = 0; k < MI3_N; k++) begin
      qinc_w[k] = (QB+1)'(q_r[QB][k]) + (QB+1)'(1);
      qh_w[k]   = qinc_w[k][QB:1];
      lim_w[k]  = neg_r[QB][k] ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
      mag_w[k]  = (ov_r[QB][k] || (qh_w[k] > lim_w[k])) ? lim_w[k][W-1:0]
                                                         : qh_w[k][W-1:0];
      if (sing_r[QB]) begin
        res_nxt[k] = '0;
      end else if (neg_r[QB][k]) begin
        res_nxt[k] = ~mag_w[k] + W'(1);
      end else begin
        res_nxt[k] = mag_w[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= res_nxt;
      out_sing_r <= sing_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[QB];
    end
  end

  assign vld_o  = out_vld_r;
  assign sing_o = out_sing_r;

  always_comb begin
    for (int k = 0; k < MI3_N; k++) begin
      r_o[k] = $signed(res_r[k]);
    end
  end

endmodule

>>> design/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a 3x3 signed fixed-point matrix by the adjugate method.
// ----------------------------------------------------------------------------
// Takes one matrix beat per cycle while in_ch.ready is high and returns one
// inverse beat per matrix, in order, through two stages for the cofactors,
// four for the exact determinant and the magnitudes, and DATA_WIDTH + 4 for
// the nine-lane restoring divider, which yields one quotient bit per stage
// and sets the latency. The whole pipeline advances whenever the output
// register is empty or being taken, so in_ch.ready follows out_ch.ready; a
// stall holds every stage. A zero determinant gives singular = 1 and an
// all-zero matrix; other elements are rounded half away from zero and
// clamped to the signed range.
module matrix3x3_inverse #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH,
  parameter int FRAC_BITS  = mi3_pkg::MI3_FRAC_BITS
) (
  input logic      clk,
  input logic      rst_n,
  mi3_in_if.sink   in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;

  logic                 en;
  logic signed [W-1:0]  a_w    [0:MI3_N-1];
  logic signed [W-1:0]  a_c    [0:MI3_N-1];
  logic signed [2*W:0]  cof_c  [0:MI3_N-1];
  logic                 vld_c;
  logic                 vld_d, sing_d;
  logic [3*W+2:0]       dmag_d;
  logic [2*W:0]         nmag_d [0:MI3_N-1];
  logic                 neg_d  [0:MI3_N-1];
  logic                 vld_q, sing_q;
  logic signed [W-1:0]  r_q    [0:MI3_N-1];

  // Advance when the output register is free
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign a_w[0] = in_ch.a00;
  assign a_w[1] = in_ch.a01;
  assign a_w[2] = in_ch.a02;
  assign a_w[3] = in_ch.a10;
  assign a_w[4] = in_ch.a11;
  assign a_w[5] = in_ch.a12;
  assign a_w[6] = in_ch.a20;
  assign a_w[7] = in_ch.a21;
  assign a_w[8] = in_ch.a22;

  mi3_cof #(.DATA_WIDTH(W)) u_cof (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_ch.valid),
    .a_i   (a_w),
    .vld_o (vld_c),
    .a_o   (a_c),
    .cof_o (cof_c)
  );

  mi3_det #(.DATA_WIDTH(W)) u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_c),
    .a_i    (a_c),
    .cof_i  (cof_c),
    .vld_o  (vld_d),
    .sing_o (sing_d),
    .dmag_o (dmag_d),
    .nmag_o (nmag_d),
    .neg_o  (neg_d)
  );

  mi3_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_d),
    .sing_i (sing_d),
    .d_i    (dmag_d),
    .n_i    (nmag_d),
    .neg_i  (neg_d),
    .vld_o  (vld_q),
    .sing_o (sing_q),
    .r_o    (r_q)
  );

  assign out_ch.valid    = vld_q;
  assign out_ch.singular = sing_q;
  assign out_ch.r00      = r_q[0];
  assign out_ch.r01      = r_q[1];
  assign out_ch.r02      = r_q[2];
  assign out_ch.r10      = r_q[3];
  assign out_ch.r11      = r_q[4];
  assign out_ch.r12      = r_q[5];
  assign out_ch.r20      = r_q[6];
  assign out_ch.r21      = r_q[7];
  assign out_ch.r22      = r_q[8];

endmodule

>>> design/mi3_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_chk
// Port-level checks on the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module mi3_chk #(
  parameter int DATA_WIDTH = mi3_pkg::MI3_DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_singular,
  input logic [DATA_WIDTH-1:0] out_r00, out_r01, out_r02,
  input logic [DATA_WIDTH-1:0] out_r10, out_r11, out_r12,
  input logic [DATA_WIDTH-1:0] out_r20, out_r21, out_r22
);

  logic [DATA_WIDTH-1:0] any_w;

  assign any_w = out_r00 | out_r01 | out_r02 | out_r10 | out_r11 | out_r12 |
                 out_r20 | out_r21 | out_r22;

  // No result beat straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // An empty output always lets a new matrix in
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A singular beat carries an all-zero matrix
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> any_w == '0)
    else $error("singular beat with nonzero element");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(any_w) && $stable(out_singular))
    else $error("stalled result beat changed");

endmodule

bind matrix3x3_inverse mi3_chk #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_singular (out_ch.singular),
  .out_r00      (out_ch.r00),
  .out_r01      (out_ch.r01),
  .out_r02      (out_ch.r02),
  .out_r10      (out_ch.r10),
  .out_r11      (out_ch.r11),
  .out_r12      (out_ch.r12),
  .out_r20      (out_ch.r20),
  .out_r21      (out_ch.r21),
  .out_r22      (out_ch.r22)
);
